FILE: rtl/reciprocal_poisson_kernel_scale_assert.svh
// ----------------------------------------------------------------------------
// reciprocal_poisson_kernel_scale assertion macros
// Concurrent assertion shorthands used by the kernel scale RTL.
// ----------------------------------------------------------------------------
`ifndef RECIPROCAL_POISSON_KERNEL_SCALE_ASSERT_SVH
`define RECIPROCAL_POISSON_KERNEL_SCALE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RPKS_ASSERT_HOLD(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RPKS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rpks_pkg.sv
// ----------------------------------------------------------------------------
// rpks_pkg
// Widths, register indexes, fixed-point constants and types of the
// reciprocal-space kernel scale block.
// ----------------------------------------------------------------------------
`default_nettype none

package rpks_pkg;

    // channel payload widths
    localparam int FREQ_W    = 8;
    localparam int COEF_W    = 32;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_METRIC_XX = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_METRIC_YY = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_METRIC_ZZ = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_METRIC_XY = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_METRIC_XZ = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_METRIC_YZ = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INV_W2    = 3'd6;

    localparam logic [DATA_W-1:0] METRIC_DIAG_RESET = 32'd65536;

    // datapath widths
    localparam int KK_W   = 17;  // index products, signed
    localparam int MET_W  = 34;  // metric operand, signed
    localparam int P_W    = 50;  // index product times metric
    localparam int G_W    = 52;  // |G|^2, signed
    localparam int X_W    = 84;  // screening argument, Q52.32
    localparam int NREM_W = 37;  // argument below the cutoff
    localparam int R_W    = 32;
    localparam int N_W    = 6;
    localparam int TERM_W = 33;
    localparam int ACC_W  = 34;
    localparam int KT_W   = 34;
    localparam int NUM_W  = COEF_W + KT_W;
    localparam int DEN_W  = G_W - 1 + 12;
    localparam int QUO_W  = 31;

    localparam int EXP_TERMS = 13;

    localparam logic [R_W-1:0]    LN2_Q32    = 32'd2977044472;
    localparam logic [31:0]       FOURPI_Q28 = 32'd3373259426;
    localparam logic [TERM_W-1:0] ONE_Q32    = 33'h1_0000_0000;
    // 33 * ln2: at or above this the tail is zero
    localparam logic [X_W-1:0]    X_LIMIT    = 84'd98242467576;

    // exact floor division of a 32-bit value by k = 1..13:
    // (v * ceil(2^(32+l)/k)) >> (32+l), l = ceil(log2 k)
    localparam logic [32:0] RCP_MUL [EXP_TERMS] = '{
        33'd4294967296, 33'd4294967296, 33'd5726623062, 33'd4294967296,
        33'd6871947674, 33'd5726623062, 33'd4908534053, 33'd4294967296,
        33'd7635497416, 33'd6871947674, 33'd6247225158, 33'd5726623062,
        33'd5286113596
    };
    localparam int RCP_SHIFT [EXP_TERMS] = '{0, 1, 2, 2, 3, 3, 3, 3, 4, 4, 4, 4, 4};

    typedef struct packed {
        logic signed [COEF_W-1:0] re;
        logic signed [COEF_W-1:0] im;
        logic                     gpos;
        logic [G_W-2:0]           g;
    } carry_t;

    typedef struct packed {
        logic [TERM_W-1:0] term;
        logic [ACC_W-1:0]  pos;
        logic [ACC_W-1:0]  neg;
        logic [R_W-1:0]    r;
        logic [N_W-1:0]    n;
        logic              huge;
    } series_t;

    typedef struct packed {
        logic gpos;
        logic neg_re;
        logic neg_im;
    } sign_t;

endpackage

`default_nettype wire

FILE: rtl/rpks_ifs.sv
// ----------------------------------------------------------------------------
// rpks channel interfaces
// Coefficient input, potential output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpks_coef_if;
    logic                               valid;
    logic                               ready;
    logic signed [rpks_pkg::FREQ_W-1:0] freq_x;
    logic signed [rpks_pkg::FREQ_W-1:0] freq_y;
    logic [rpks_pkg::FREQ_W-1:0]        freq_z;
    logic signed [rpks_pkg::COEF_W-1:0] coef_re;
    logic signed [rpks_pkg::COEF_W-1:0] coef_im;

    modport source (output valid, freq_x, freq_y, freq_z, coef_re, coef_im, input ready);
    modport sink (input valid, freq_x, freq_y, freq_z, coef_re, coef_im, output ready);
endinterface

interface rpks_pot_if;
    logic                               valid;
    logic                               ready;
    logic signed [rpks_pkg::COEF_W-1:0] pot_re;
    logic signed [rpks_pkg::COEF_W-1:0] pot_im;

    modport source (output valid, pot_re, pot_im, input ready);
    modport sink (input valid, pot_re, pot_im, output ready);
endinterface

interface rpks_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rpks_pkg::REG_IDX_W-1:0]    index;
    logic [rpks_pkg::DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/rpks_div.sv
// ----------------------------------------------------------------------------
// rpks_div
// Pipelined restoring divider, one quotient bit per stage, with a
// saturation flag for quotients that do not fit in QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rpks_div #(
    parameter int NUM_W = rpks_pkg::NUM_W,
    parameter int DEN_W = rpks_pkg::DEN_W,
    parameter int QUO_W = rpks_pkg::QUO_W
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo,
    output logic                  sat
);

    localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [REM_W-1:0] rem_reg [QUO_W+1];
    logic [DEN_W-1:0] den_reg [QUO_W+1];
    logic [QUO_W-1:0] quo_reg [QUO_W+1];
    logic             sat_reg [QUO_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= REM_W'(num);
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            sat_reg[0] <= REM_W'(num) >= (REM_W'(den) << QUO_W);
        end
    end

    for (genvar i = 1; i <= QUO_W; i++)
    begin : g_step
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        always_comb
        begin
            trial    = REM_W'(den_reg[i-1]) << (QUO_W - i);
            rem_next = rem_reg[i-1];
            quo_next = quo_reg[i-1];
            if (rem_reg[i-1] >= trial)
            begin
                rem_next            = rem_reg[i-1] - trial;
                quo_next[QUO_W - i] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_reg[i-1];
                quo_reg[i] <= quo_next;
                sat_reg[i] <= sat_reg[i-1];
            end
        end
    end

    assign quo = quo_reg[QUO_W];
    assign sat = sat_reg[QUO_W];

endmodule

`default_nettype wire

FILE: rtl/reciprocal_poisson_kernel_scale.sv
// ----------------------------------------------------------------------------
// reciprocal_poisson_kernel_scale
// Scales a complex spectral coefficient by the screened Coulomb kernel
// 4*pi/|G|^2 * exp(-|G|^2 / (4 omega^2)), Q16.16, saturated.
//
// Usage:
//   cfg  - register writes (metric xx, yy, zz, xy, xz, yz, screening);
//          always ready, index seven is ignored. Write only while idle.
//   coef - one transaction per coefficient with its frequency indices.
//   pot  - one transaction per coefficient, in order.
// The item passes 71 registers, the first loaded at the accepting edge: index
// products, metric multiply, sum, two argument stages, two range-reduction
// stages, two stages per exp series term (13 terms), five stages to the
// dividend, a divider setup stage, 31 divider stages (one quotient bit each)
// and the output register. Throughput is one transaction per cycle while
// coef.ready is high, that is while the skid entry is empty.
// Reset restores the identity metric with no screening and empties the
// pipeline. When pot stalls, the output register and one skid entry absorb
// the items in flight; coef.ready drops once the skid entry is full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "reciprocal_poisson_kernel_scale_assert.svh"

module reciprocal_poisson_kernel_scale (
    input wire logic clk,
    input wire logic rst_n,
    rpks_cfg_if.sink  cfg,
    rpks_coef_if.sink coef,
    rpks_pot_if.source pot
);

    localparam int ST_XPP  = 3;
    localparam int ST_SER  = 7;
    localparam int ST_KT   = ST_SER + 2 * rpks_pkg::EXP_TERMS + 3;
    localparam int ST_NUM  = ST_KT + 1;
    localparam int DIV_LAT = rpks_pkg::QUO_W + 1;
    localparam int NSTAGE  = ST_NUM + 1 + DIV_LAT;

    // ---------------- configuration registers ----------------
    logic [rpks_pkg::DATA_W-1:0]        metric_xx_reg;
    logic [rpks_pkg::DATA_W-1:0]        metric_yy_reg;
    logic [rpks_pkg::DATA_W-1:0]        metric_zz_reg;
    logic signed [rpks_pkg::DATA_W-1:0] metric_xy_reg;
    logic signed [rpks_pkg::DATA_W-1:0] metric_xz_reg;
    logic signed [rpks_pkg::DATA_W-1:0] metric_yz_reg;
    logic [rpks_pkg::DATA_W-1:0]        inv_w2_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_xx_reg <= rpks_pkg::METRIC_DIAG_RESET;
            metric_yy_reg <= rpks_pkg::METRIC_DIAG_RESET;
            metric_zz_reg <= rpks_pkg::METRIC_DIAG_RESET;
            metric_xy_reg <= '0;
            metric_xz_reg <= '0;
            metric_yz_reg <= '0;
            inv_w2_reg    <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                rpks_pkg::REG_METRIC_XX: metric_xx_reg <= cfg.data;
                rpks_pkg::REG_METRIC_YY: metric_yy_reg <= cfg.data;
                rpks_pkg::REG_METRIC_ZZ: metric_zz_reg <= cfg.data;
                rpks_pkg::REG_METRIC_XY: metric_xy_reg <= cfg.data;
                rpks_pkg::REG_METRIC_XZ: metric_xz_reg <= cfg.data;
                rpks_pkg::REG_METRIC_YZ: metric_yz_reg <= cfg.data;
                rpks_pkg::REG_INV_W2:    inv_w2_reg    <= cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic skid_full_reg;
    logic out_valid_reg;
    logic vld_reg [NSTAGE];

    assign en         = !skid_full_reg;
    assign coef.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTAGE; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= coef.valid;
            for (int i = 1; i < NSTAGE; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // coefficient and |G|^2 ride along up to the dividend stage
    rpks_pkg::carry_t car_reg  [ST_NUM];
    rpks_pkg::carry_t car_next [ST_NUM];
    logic signed [rpks_pkg::G_W-1:0] g_sum_reg;

    always_comb
    begin
        car_next[0].re   = coef.coef_re;
        car_next[0].im   = coef.coef_im;
        car_next[0].gpos = 1'b0;
        car_next[0].g    = '0;
        for (int i = 1; i < ST_NUM; i++)
        begin
            car_next[i] = car_reg[i-1];
            if (i == ST_XPP)
            begin
                car_next[i].gpos = !g_sum_reg[rpks_pkg::G_W-1] && (g_sum_reg != '0);
                car_next[i].g    = g_sum_reg[rpks_pkg::G_W-2:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ST_NUM; i++)
                car_reg[i] <= car_next[i];
        end
    end

    // ---------------- |G|^2 = k^T M k ----------------
    logic signed [rpks_pkg::KK_W-1:0]  fx, fy, fz;
    logic signed [rpks_pkg::KK_W-1:0]  kxx_reg, kyy_reg, kzz_reg, kxy_reg, kxz_reg, kyz_reg;
    logic signed [rpks_pkg::MET_W-1:0] mxx, myy, mzz, mxy, mxz, myz;
    logic signed [rpks_pkg::P_W-1:0]   pxx_reg, pyy_reg, pzz_reg, pxy_reg, pxz_reg, pyz_reg;

    assign fx  = rpks_pkg::KK_W'(coef.freq_x);
    assign fy  = rpks_pkg::KK_W'(coef.freq_y);
    assign fz  = {{(rpks_pkg::KK_W - rpks_pkg::FREQ_W){1'b0}}, coef.freq_z};
    assign mxx = {2'b00, metric_xx_reg};
    assign myy = {2'b00, metric_yy_reg};
    assign mzz = {2'b00, metric_zz_reg};
    assign mxy = rpks_pkg::MET_W'(metric_xy_reg);
    assign mxz = rpks_pkg::MET_W'(metric_xz_reg);
    assign myz = rpks_pkg::MET_W'(metric_yz_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kxx_reg <= fx * fx;
            kyy_reg <= fy * fy;
            kzz_reg <= fz * fz;
            kxy_reg <= fx * fy;
            kxz_reg <= fx * fz;
            kyz_reg <= fy * fz;

            pxx_reg <= kxx_reg * mxx;
            pyy_reg <= kyy_reg * myy;
            pzz_reg <= kzz_reg * mzz;
            pxy_reg <= kxy_reg * mxy;
            pxz_reg <= kxz_reg * mxz;
            pyz_reg <= kyz_reg * myz;

            g_sum_reg <= rpks_pkg::G_W'(pxx_reg) + rpks_pkg::G_W'(pyy_reg)
                       + rpks_pkg::G_W'(pzz_reg)
                       + ((rpks_pkg::G_W'(pxy_reg) + rpks_pkg::G_W'(pxz_reg)
                         + rpks_pkg::G_W'(pyz_reg)) <<< 1);
        end
    end

    // ---------------- screening argument and range reduction ----------------
    localparam logic [rpks_pkg::NREM_W-1:0] LN2_EXT = rpks_pkg::NREM_W'(rpks_pkg::LN2_Q32);

    logic [63:0]                  glo_reg;
    logic [rpks_pkg::G_W-1:0]     ghi_reg;
    logic [rpks_pkg::X_W-1:0]     x_reg;
    logic [rpks_pkg::NREM_W-1:0]  nrem_reg;
    logic [2:0]                   nhi_reg;
    logic                         huge_reg;
    logic [rpks_pkg::NREM_W-1:0]  rem_hi, rem_lo;
    logic [2:0]                   nhi_next, nlo_next;
    rpks_pkg::series_t            ser_a_reg [rpks_pkg::EXP_TERMS];
    rpks_pkg::series_t            ser_b_reg [rpks_pkg::EXP_TERMS+1];
    rpks_pkg::series_t            ser_start;

    always_comb
    begin
        rem_hi   = x_reg[rpks_pkg::NREM_W-1:0];
        nhi_next = '0;
        for (int b = 5; b >= 3; b--)
        begin
            if (rem_hi >= (LN2_EXT << b))
            begin
                rem_hi        = rem_hi - (LN2_EXT << b);
                nhi_next[b-3] = 1'b1;
            end
        end
    end

    always_comb
    begin
        rem_lo   = nrem_reg;
        nlo_next = '0;
        for (int b = 2; b >= 0; b--)
        begin
            if (rem_lo >= (LN2_EXT << b))
            begin
                rem_lo      = rem_lo - (LN2_EXT << b);
                nlo_next[b] = 1'b1;
            end
        end
        ser_start.term = rpks_pkg::ONE_Q32;
        ser_start.pos  = rpks_pkg::ACC_W'(rpks_pkg::ONE_Q32);
        ser_start.neg  = '0;
        ser_start.r    = rem_lo[rpks_pkg::R_W-1:0];
        ser_start.n    = {nhi_reg, nlo_next};
        ser_start.huge = huge_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            glo_reg      <= g_sum_reg[31:0] * inv_w2_reg;
            ghi_reg      <= g_sum_reg[rpks_pkg::G_W-1:32] * inv_w2_reg;
            x_reg        <= rpks_pkg::X_W'(glo_reg) + {ghi_reg, 32'b0};
            huge_reg     <= x_reg >= rpks_pkg::X_LIMIT;
            nrem_reg     <= rem_hi;
            nhi_reg      <= nhi_next;
            ser_b_reg[0] <= ser_start;
        end
    end

    // ---------------- exp(-r) series, two stages per term ----------------
    for (genvar k = 0; k < rpks_pkg::EXP_TERMS; k++)
    begin : g_term
        logic [rpks_pkg::TERM_W+rpks_pkg::R_W-1:0] mul_a;
        logic [rpks_pkg::R_W+33-1:0]               mul_b;
        rpks_pkg::series_t                         a_next, b_next;

        always_comb
        begin
            mul_a  = ser_b_reg[k].term * ser_b_reg[k].r;
            a_next = ser_b_reg[k];
            // fold in the term finished by the previous pair of stages
            if (k > 0)
            begin
                if ((k % 2) == 1)
                    a_next.neg = ser_b_reg[k].neg + rpks_pkg::ACC_W'(ser_b_reg[k].term);
                else
                    a_next.pos = ser_b_reg[k].pos + rpks_pkg::ACC_W'(ser_b_reg[k].term);
            end
            a_next.term = rpks_pkg::TERM_W'(mul_a[rpks_pkg::R_W +: rpks_pkg::R_W]);

            mul_b       = ser_a_reg[k].term[rpks_pkg::R_W-1:0] * rpks_pkg::RCP_MUL[k];
            b_next      = ser_a_reg[k];
            b_next.term = rpks_pkg::TERM_W'(mul_b >> (rpks_pkg::R_W + rpks_pkg::RCP_SHIFT[k]));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ser_a_reg[k]   <= a_next;
                ser_b_reg[k+1] <= b_next;
            end
        end
    end

    // ---------------- tail, kernel and dividend ----------------
    rpks_pkg::series_t acc_reg;
    rpks_pkg::series_t acc_next;
    logic [rpks_pkg::ACC_W-1:0]        e_reg;
    logic [rpks_pkg::N_W-1:0]          e_n_reg;
    logic                              e_huge_reg;
    logic [rpks_pkg::ACC_W-1:0]        tail_reg;
    logic [32+rpks_pkg::ACC_W-1:0]     kt_prod;
    logic [rpks_pkg::KT_W-1:0]         kt_reg;
    logic [rpks_pkg::COEF_W-1:0]       mag_re, mag_im;
    logic [rpks_pkg::NUM_W-1:0]        num_re_reg, num_im_reg;
    logic [rpks_pkg::DEN_W-1:0]        den_reg;
    rpks_pkg::sign_t                   sgn_reg [DIV_LAT+1];

    always_comb
    begin
        // last term has an odd index
        acc_next     = ser_b_reg[rpks_pkg::EXP_TERMS];
        acc_next.neg = ser_b_reg[rpks_pkg::EXP_TERMS].neg
                     + rpks_pkg::ACC_W'(ser_b_reg[rpks_pkg::EXP_TERMS].term);
        kt_prod      = rpks_pkg::FOURPI_Q28 * tail_reg;
        mag_re       = car_reg[ST_NUM-1].re[rpks_pkg::COEF_W-1]
                     ? rpks_pkg::COEF_W'(0) - car_reg[ST_NUM-1].re : car_reg[ST_NUM-1].re;
        mag_im       = car_reg[ST_NUM-1].im[rpks_pkg::COEF_W-1]
                     ? rpks_pkg::COEF_W'(0) - car_reg[ST_NUM-1].im : car_reg[ST_NUM-1].im;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg    <= acc_next;
            e_reg      <= (acc_reg.pos > acc_reg.neg) ? acc_reg.pos - acc_reg.neg : '0;
            e_n_reg    <= acc_reg.n;
            e_huge_reg <= acc_reg.huge;
            tail_reg   <= e_huge_reg ? '0 : (e_reg >> e_n_reg);
            kt_reg     <= kt_prod[32 +: rpks_pkg::KT_W];
            num_re_reg <= mag_re * kt_reg;
            num_im_reg <= mag_im * kt_reg;
            den_reg    <= {car_reg[ST_NUM-1].g, 12'b0};
            sgn_reg[0] <= '{gpos:   car_reg[ST_NUM-1].gpos,
                            neg_re: car_reg[ST_NUM-1].re[rpks_pkg::COEF_W-1],
                            neg_im: car_reg[ST_NUM-1].im[rpks_pkg::COEF_W-1]};
            for (int i = 1; i <= DIV_LAT; i++)
                sgn_reg[i] <= sgn_reg[i-1];
        end
    end

    // ---------------- division ----------------
    logic [rpks_pkg::QUO_W-1:0] quo_re, quo_im;
    logic                       sat_re, sat_im;

    rpks_div #(
        .NUM_W (rpks_pkg::NUM_W),
        .DEN_W (rpks_pkg::DEN_W),
        .QUO_W (rpks_pkg::QUO_W)
    ) u_div_re (
        .clk (clk),
        .en  (en),
        .num (num_re_reg),
        .den (den_reg),
        .quo (quo_re),
        .sat (sat_re)
    );

    rpks_div #(
        .NUM_W (rpks_pkg::NUM_W),
        .DEN_W (rpks_pkg::DEN_W),
        .QUO_W (rpks_pkg::QUO_W)
    ) u_div_im (
        .clk (clk),
        .en  (en),
        .num (num_im_reg),
        .den (den_reg),
        .quo (quo_im),
        .sat (sat_im)
    );

    // ---------------- sign, saturation and output ----------------
    localparam logic [rpks_pkg::COEF_W-1:0] SAT_POS = {1'b0, {(rpks_pkg::COEF_W-1){1'b1}}};
    localparam logic [rpks_pkg::COEF_W-1:0] SAT_NEG = {1'b1, {(rpks_pkg::COEF_W-1){1'b0}}};

    logic [rpks_pkg::COEF_W-1:0] res_re, res_im;
    logic [rpks_pkg::COEF_W-1:0] out_re_reg, out_im_reg, skid_re_reg, skid_im_reg;
    logic                        push, pop;

    always_comb
    begin
        if (!sgn_reg[DIV_LAT].gpos)
            res_re = '0;
        else if (sgn_reg[DIV_LAT].neg_re)
            res_re = sat_re ? SAT_NEG : rpks_pkg::COEF_W'(0) - rpks_pkg::COEF_W'(quo_re);
        else
            res_re = sat_re ? SAT_POS : rpks_pkg::COEF_W'(quo_re);

        if (!sgn_reg[DIV_LAT].gpos)
            res_im = '0;
        else if (sgn_reg[DIV_LAT].neg_im)
            res_im = sat_im ? SAT_NEG : rpks_pkg::COEF_W'(0) - rpks_pkg::COEF_W'(quo_im);
        else
            res_im = sat_im ? SAT_POS : rpks_pkg::COEF_W'(quo_im);
    end

    assign push = vld_reg[NSTAGE-1] && en;
    assign pop  = out_valid_reg && pot.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (pop)
                skid_full_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_full_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (pop)
            begin
                out_re_reg <= skid_re_reg;
                out_im_reg <= skid_im_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_re_reg <= res_re;
                out_im_reg <= res_im;
            end
            else
            begin
                skid_re_reg <= res_re;
                skid_im_reg <= res_im;
            end
        end
    end

    assign pot.valid  = out_valid_reg;
    assign pot.pot_re = out_re_reg;
    assign pot.pot_im = out_im_reg;

    // ---------------- assertions ----------------
    `RPKS_ASSERT_HOLD(a_skid_implies_out, clk, rst_n, skid_full_reg, out_valid_reg, "skid no out")
    `RPKS_ASSERT_HOLD(a_skid_blocks_input, clk, rst_n, skid_full_reg, !coef.ready, "skid ready")
    `RPKS_ASSERT_NEXT(a_accept_enters, clk, rst_n, coef.valid && coef.ready, vld_reg[0], "lost")
    `RPKS_ASSERT_NEXT(a_stall_holds_tail, clk, rst_n, !en, $stable(vld_reg[NSTAGE-1]), "moved")

endmodule

`default_nettype wire
